// ===== hw/rtl/cns_pkg.sv =====
package cns_pkg;

    localparam int DEFAULT_MAX_DEPTH = 64;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;
    localparam int NEST_DEPTH_W = 7;

    localparam logic [2:0] MODE_IF    = 3'd0;
    localparam logic [2:0] MODE_ELIF  = 3'd1;
    localparam logic [2:0] MODE_ELSE  = 3'd2;
    localparam logic [2:0] MODE_ENDIF = 3'd3;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_NO_NAME    = 3'd1;
    localparam logic [2:0] ERR_NO_IF      = 3'd2;
    localparam logic [2:0] ERR_AFTER_ELSE = 3'd3;
    localparam logic [2:0] ERR_UNMATCHED  = 3'd4;
    localparam logic [2:0] ERR_NEEDS_C23  = 3'd5;
    localparam logic [2:0] ERR_OVERFLOW   = 3'd6;

    typedef struct packed {
        logic pskip;
        logic seen_else;
        logic any;
        logic taken;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic exec;
        logic load_top;
    } cmd_t;

    typedef struct packed {
        logic fetch_needed;
        logic out_valid;
    } status_t;

    function automatic logic entry_skip(entry_t e);
        return e.pskip | ~e.taken;
    endfunction

endpackage

// ===== hw/rtl/conditional_nesting_stack.sv =====
// Conditional nesting stack: tracks nested preprocessor conditional groups.
// Input channel (s_*): one directive per transfer, condition already
// evaluated. Result channel (m_*): one result per directive with the skip
// flag, process flag for other directives, nesting depth and error code.
// Configuration channel (cfg_*): one bit, enables the elifdef/elifndef forms;
// write it only while no directive is in flight.
// Output: the result is registered and shows on m_tvalid in the cycle after
// the input transfer. Throughput: one directive per cycle unless m_tready
// holds the result; an endif leaving one or more groups open also blocks
// input during the stack memory read that restores the new top entry (the
// top entry lives in a register, those below it in a single-port-read RAM).
// Stalls: the result register holds while m_tready is low; a new input is
// taken in the same cycle that the held result is transferred.
// Reset: depth, skip flag and the configuration bit clear; the stack memory
// is not cleared, as no entry is read before it has been written.
module conditional_nesting_stack #(
    parameter int MAX_DEPTH = cns_pkg::DEFAULT_MAX_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [2:0] mode, [3] cond_value, [4] name_ok, [5] name_form, [6] is_c23_form
    input  logic [cns_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] skip, [1] process_other, [8:2] nest_depth, [11:9] error_code
    output logic [cns_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_data
);

    cns_pkg::cmd_t    cmd;
    cns_pkg::status_t st;
    logic             s_accept;

    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;

    cns_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    cns_datapath #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    a_accept_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |-> (!m_tvalid || m_tready))
        else $error("input accepted while a result is held");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid)
        else $error("accepted directive produced no result");

    a_fetch_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && st.fetch_needed) |=> (!s_tready && cmd.load_top))
        else $error("input taken during top entry restore");

endmodule

// ===== hw/rtl/cns_ram.sv =====
module cns_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/cns_ctrl.sv =====
module cns_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              m_tready,
    input  cns_pkg::status_t  st,
    output cns_pkg::cmd_t     cmd
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_FETCH = 2'b10
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE) && (!st.out_valid || m_tready);

    always_comb begin
        cmd.exec     = s_tvalid && s_tready;
        cmd.load_top = 1'b0;
        state_next   = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.exec && st.fetch_needed) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                // new top entry arrives from the stack memory
                cmd.load_top = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/cns_datapath.sv =====
module cns_datapath #(
    parameter int MAX_DEPTH = cns_pkg::DEFAULT_MAX_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  cns_pkg::cmd_t                    cmd,
    output cns_pkg::status_t                 st,
    input  logic [cns_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                             cfg_valid,
    input  logic                             cfg_data,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cns_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int NW = cns_pkg::NEST_DEPTH_W;

    logic [2:0] mode;
    logic       cond_value, name_ok, name_form, is_c23_form;

    assign mode        = s_tdata[2:0];
    assign cond_value  = s_tdata[3];
    assign name_ok     = s_tdata[4];
    assign name_form   = s_tdata[5];
    assign is_c23_form = s_tdata[6];

    logic [DW-1:0]   depth_reg, depth_next;
    logic            skip_reg, skip_next;
    logic            c23_reg;
    cns_pkg::entry_t top_reg, top_next;

    logic [2:0] err;
    logic       proc;
    logic       push_wr;
    logic       name_bad;

    logic                        out_valid_reg;
    logic [cns_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic [DW+NW-1:0]            depth_ext;

    logic [AW-1:0]               wr_addr, rd_addr;
    logic [DW-1:0]               depth_m1, depth_m2;
    logic [cns_pkg::ENTRY_W-1:0] rd_data;

    assign depth_m1 = depth_reg - DW'(1);
    assign depth_m2 = depth_reg - DW'(2);
    assign wr_addr  = depth_m1[AW-1:0];
    assign rd_addr  = depth_m2[AW-1:0];
    assign name_bad = name_form && !name_ok;

    always_comb begin
        depth_next = depth_reg;
        skip_next  = skip_reg;
        top_next   = top_reg;
        err        = cns_pkg::ERR_NONE;
        proc       = 1'b0;
        push_wr    = 1'b0;
        case (mode)
            cns_pkg::MODE_IF: begin
                if (name_bad) begin
                    err = cns_pkg::ERR_NO_NAME;
                end else if (depth_reg >= DW'(MAX_DEPTH)) begin
                    err = cns_pkg::ERR_OVERFLOW;
                end else begin
                    top_next       = '0;
                    top_next.pskip = skip_reg;
                    top_next.taken = !skip_reg && cond_value;
                    top_next.any   = !skip_reg && cond_value;
                    // spill the current top below the new one
                    push_wr        = (depth_reg != '0);
                    depth_next     = depth_reg + DW'(1);
                    skip_next      = cns_pkg::entry_skip(top_next);
                end
            end
            cns_pkg::MODE_ELIF: begin
                if (is_c23_form && !c23_reg) begin
                    err = cns_pkg::ERR_NEEDS_C23;
                end else if (depth_reg == '0) begin
                    err = cns_pkg::ERR_NO_IF;
                end else if (top_reg.seen_else) begin
                    err = cns_pkg::ERR_AFTER_ELSE;
                end else if (name_bad) begin
                    err = cns_pkg::ERR_NO_NAME;
                end else begin
                    if (!top_reg.any && cond_value) begin
                        top_next.taken = 1'b1;
                        top_next.any   = 1'b1;
                    end else begin
                        top_next.taken = 1'b0;
                    end
                    skip_next = cns_pkg::entry_skip(top_next);
                end
            end
            cns_pkg::MODE_ELSE: begin
                if (depth_reg == '0) begin
                    err = cns_pkg::ERR_NO_IF;
                end else if (top_reg.seen_else) begin
                    err = cns_pkg::ERR_AFTER_ELSE;
                end else begin
                    top_next.taken     = !top_reg.any;
                    top_next.any       = 1'b1;
                    top_next.seen_else = 1'b1;
                    skip_next          = cns_pkg::entry_skip(top_next);
                end
            end
            cns_pkg::MODE_ENDIF: begin
                if (depth_reg == '0) begin
                    err = cns_pkg::ERR_UNMATCHED;
                end else begin
                    depth_next = depth_m1;
                    skip_next  = top_reg.pskip;
                end
            end
            default: begin
                proc = !skip_reg;
            end
        endcase
    end

    assign st.fetch_needed = (mode == cns_pkg::MODE_ENDIF) && (depth_reg >= DW'(2));
    assign st.out_valid    = out_valid_reg;

    cns_ram #(
        .WIDTH (cns_pkg::ENTRY_W),
        .DEPTH (MAX_DEPTH),
        .AW    (AW)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (cmd.exec && push_wr),
        .wr_addr (wr_addr),
        .wr_data (top_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign depth_ext = {{NW{1'b0}}, depth_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg     <= '0;
            skip_reg      <= 1'b0;
            c23_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                c23_reg <= cfg_data;
            end
            if (cmd.exec) begin
                depth_reg     <= depth_next;
                skip_reg      <= skip_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            top_reg      <= top_next;
            out_data_reg <= {4'b0, err, depth_ext[NW-1:0], proc, skip_next};
        end else if (cmd.load_top) begin
            top_reg <= cns_pkg::entry_t'(rd_data);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== tb/tb.sv =====
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cns_pkg::*;

    localparam int DEPTH_LIMIT = cns_pkg::DEFAULT_MAX_DEPTH;
    localparam logic [2:0] MODE_OTHER = 3'd4;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_PRINTED = 50;

    // receiver stall styles
    localparam int RX_ALWAYS   = 0;
    localparam int RX_RANDOM   = 1;
    localparam int RX_SPARSE   = 2;
    localparam int RX_PERIODIC = 3;

    typedef struct packed {
        logic       is_c23;
        logic       name_form;
        logic       name_ok;
        logic       cond;
        logic [2:0] mode;
    } directive_t;

    typedef struct packed {
        logic [2:0] err;
        logic [6:0] depth;
        logic       proc;
        logic       skip;
    } outcome_t;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_data;

    conditional_nesting_stack dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // group tracker mirror
    entry_t grp_stack [DEPTH_LIMIT];
    int     grp_depth;
    logic   grp_skip;
    logic   c23_en;

    outcome_t outcome_q[$];
    int mismatches;
    int results_seen;

    int burst_left;
    int gap_max;
    bit rx_free;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic outcome_t advance_groups(input directive_t d);
        outcome_t r;
        entry_t e;
        r = '0;
        case (d.mode)
            MODE_IF: begin
                if (d.name_form && !d.name_ok) begin
                    r.err = ERR_NO_NAME;
                end else if (grp_depth >= DEPTH_LIMIT) begin
                    r.err = ERR_OVERFLOW;
                end else begin
                    e = '0;
                    // a group opened under a skipped parent is always skipped
                    if (grp_skip) begin
                        e.pskip = 1'b1;
                    end else if (d.cond) begin
                        e.taken = 1'b1;
                        e.any = 1'b1;
                    end
                    grp_stack[grp_depth] = e;
                    grp_depth++;
                    grp_skip = e.pskip | ~e.taken;
                end
            end
            MODE_ELIF: begin
                if (d.is_c23 && !c23_en) begin
                    r.err = ERR_NEEDS_C23;
                end else if (grp_depth == 0) begin
                    r.err = ERR_NO_IF;
                end else begin
                    e = grp_stack[grp_depth-1];
                    if (e.seen_else) begin
                        r.err = ERR_AFTER_ELSE;
                    end else if (d.name_form && !d.name_ok) begin
                        r.err = ERR_NO_NAME;
                    end else begin
                        if (!e.any && d.cond) begin
                            e.taken = 1'b1;
                            e.any = 1'b1;
                        end else begin
                            e.taken = 1'b0;
                        end
                        grp_stack[grp_depth-1] = e;
                        grp_skip = e.pskip | ~e.taken;
                    end
                end
            end
            MODE_ELSE: begin
                if (grp_depth == 0) begin
                    r.err = ERR_NO_IF;
                end else begin
                    e = grp_stack[grp_depth-1];
                    if (e.seen_else) begin
                        r.err = ERR_AFTER_ELSE;
                    end else begin
                        if (e.any) begin
                            e.taken = 1'b0;
                        end else begin
                            e.taken = 1'b1;
                            e.any = 1'b1;
                        end
                        e.seen_else = 1'b1;
                        grp_stack[grp_depth-1] = e;
                        grp_skip = e.pskip | ~e.taken;
                    end
                end
            end
            MODE_ENDIF: begin
                if (grp_depth == 0) begin
                    r.err = ERR_UNMATCHED;
                end else begin
                    e = grp_stack[grp_depth-1];
                    grp_depth--;
                    grp_skip = e.pskip;
                end
            end
            default: begin
                r.proc = ~grp_skip;
            end
        endcase
        r.skip = grp_skip;
        r.depth = grp_depth[6:0];
        return r;
    endfunction

    function automatic directive_t mk_dir(input logic [2:0] m, input logic c = 1'b0,
                                          input logic nf = 1'b0, input logic ok = 1'b1,
                                          input logic c23f = 1'b0);
        directive_t d;
        d.mode = m;
        d.cond = c;
        d.name_form = nf;
        d.name_ok = ok;
        d.is_c23 = c23f;
        return d;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("[%0t] mismatch on %s: got %0d, expected %0d (result %0d)",
                     $realtime, what, got, want, results_seen);
    endtask

    // Send one directive; keep tvalid high inside a burst, insert a gap between bursts.
    task automatic push_directive(input directive_t d);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            burst_left = $urandom_range(1, 16);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, d};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        outcome_q.push_back(advance_groups(d));
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (outcome_q.size() != 0) @(posedge aclk);
        // an endif may still be restoring the top entry
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_c23(input logic v);
        drain_results();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        c23_en = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly well-formed nesting that drifts toward a target depth, plus some noise.
    function automatic directive_t random_directive(input int target);
        directive_t d;
        int s;
        int w_open;
        int w_endif;
        if ($urandom_range(0, 99) < 6) begin
            d = directive_t'(7'($urandom_range(0, 127)));
            return d;
        end
        if (grp_depth < target) begin
            w_open = (target > DEPTH_LIMIT) ? 70 : 45;
            w_endif = 8;
        end else if (grp_depth > target) begin
            w_open = 10;
            w_endif = 45;
        end else begin
            w_open = 25;
            w_endif = 25;
        end
        s = $urandom_range(0, 99);
        d.cond = 1'($urandom_range(0, 1));
        d.name_form = 1'($urandom_range(0, 1));
        d.name_ok = ($urandom_range(0, 9) != 0);
        d.is_c23 = 1'($urandom_range(0, 1));
        if (s < w_open)
            d.mode = MODE_IF;
        else if (s < w_open + 12)
            d.mode = MODE_ELIF;
        else if (s < w_open + 20)
            d.mode = MODE_ELSE;
        else if (s < w_open + 20 + w_endif)
            d.mode = MODE_ENDIF;
        else
            d.mode = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(5, 7)) : MODE_OTHER;
        return d;
    endfunction

    task automatic test_error_cases();
        gap_max = 3;
        push_directive(mk_dir(MODE_ELSE));
        push_directive(mk_dir(MODE_ENDIF));
        push_directive(mk_dir(MODE_ELIF, 1'b1, 1'b1, 1'b1, 1'b1));
        push_directive(mk_dir(MODE_ELIF, 1'b1));
        push_directive(mk_dir(MODE_OTHER));
        push_directive(mk_dir(MODE_IF, 1'b1, 1'b1, 1'b0));
        push_directive(mk_dir(3'd7, 1'b1, 1'b1, 1'b0, 1'b1));
        push_directive(mk_dir(MODE_ELSE, 1'b1, 1'b1, 1'b0, 1'b1));
    endtask

    task automatic test_group_branches();
        push_directive(mk_dir(MODE_IF, 1'b1));
        push_directive(mk_dir(MODE_OTHER));
        push_directive(mk_dir(MODE_ELIF, 1'b1));
        push_directive(mk_dir(MODE_OTHER));
        push_directive(mk_dir(MODE_ELSE));
        push_directive(mk_dir(MODE_ELIF, 1'b1));
        push_directive(mk_dir(MODE_ELSE));
        push_directive(mk_dir(MODE_ENDIF, 1'b1, 1'b1, 1'b0, 1'b1));
        push_directive(mk_dir(MODE_IF, 1'b0, 1'b1, 1'b1));
        push_directive(mk_dir(MODE_ELIF, 1'b0));
        push_directive(mk_dir(MODE_ELIF, 1'b1));
        push_directive(mk_dir(MODE_ELIF, 1'b1, 1'b1, 1'b0));
        push_directive(mk_dir(MODE_ELSE));
        push_directive(mk_dir(MODE_ENDIF));
        // nested group under a false parent stays skipped through else
        push_directive(mk_dir(MODE_IF, 1'b0));
        push_directive(mk_dir(MODE_IF, 1'b1));
        push_directive(mk_dir(MODE_ELSE));
        push_directive(mk_dir(3'd5, 1'b1, 1'b1, 1'b1, 1'b1));
        push_directive(mk_dir(MODE_ENDIF));
        push_directive(mk_dir(MODE_ELSE));
        push_directive(mk_dir(3'd6));
        push_directive(mk_dir(MODE_ENDIF));
    endtask

    task automatic test_c23_forms();
        write_c23(1'b1);
        push_directive(mk_dir(MODE_IF, 1'b0, 1'b1, 1'b1));
        push_directive(mk_dir(MODE_ELIF, 1'b1, 1'b1, 1'b1, 1'b1));
        push_directive(mk_dir(MODE_ELIF, 1'b1, 1'b1, 1'b0, 1'b1));
        push_directive(mk_dir(MODE_ELSE));
        push_directive(mk_dir(MODE_ELIF, 1'b1, 1'b1, 1'b1, 1'b1));
        push_directive(mk_dir(MODE_ENDIF));
        push_directive(mk_dir(MODE_ELIF, 1'b1, 1'b1, 1'b1, 1'b1));
        write_c23(1'b0);
        push_directive(mk_dir(MODE_IF, 1'b1));
        push_directive(mk_dir(MODE_ELIF, 1'b1, 1'b1, 1'b0, 1'b1));
        push_directive(mk_dir(MODE_ENDIF));
    endtask

    task automatic test_overflow();
        gap_max = 2;
        repeat (DEPTH_LIMIT)
            push_directive(mk_dir(MODE_IF, 1'($urandom_range(0, 7) != 0),
                                  1'($urandom_range(0, 1))));
        push_directive(mk_dir(MODE_IF, 1'b1));
        push_directive(mk_dir(MODE_IF, 1'b1, 1'b1, 1'b0));
        push_directive(mk_dir(MODE_ELIF, 1'b1));
        push_directive(mk_dir(MODE_ELSE));
        push_directive(mk_dir(MODE_OTHER));
        repeat (DEPTH_LIMIT) push_directive(mk_dir(MODE_ENDIF));
        push_directive(mk_dir(MODE_ENDIF));
    endtask

    task automatic run_random_phase(input int n, input logic c23, input int gaps,
                                    input bit free_rx, input bit deep);
        int target;
        int hold;
        write_c23(c23);
        gap_max = gaps;
        rx_free = free_rx;
        hold = 0;
        target = 0;
        for (int i = 0; i < n; i++) begin
            if (hold == 0) begin
                if (deep && $urandom_range(0, 2) == 0) begin
                    target = DEPTH_LIMIT + 2;
                    hold = 160;
                end else begin
                    target = $urandom_range(0, 6);
                    hold = 40;
                end
            end
            hold--;
            push_directive(random_directive(target));
        end
        rx_free = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_random_phase(200, 1'b0, 6, 1'b0, 1'b0);
        run_random_phase(200, 1'b1, 12, 1'b0, 1'b0);
        run_random_phase(120, 1'b1, 0, 1'b1, 1'b0);
        run_random_phase(200, 1'b0, 4, 1'b0, 1'b1);
        run_random_phase(200, 1'b1, 8, 1'b0, 1'b1);
    endtask

    // receiver: switch to a randomly chosen stall style after each span of random length
    initial begin
        int style;
        int span;
        int period;
        int tick;
        m_tready = 1'b0;
        tick = 0;
        forever begin
            style = $urandom_range(RX_ALWAYS, RX_PERIODIC);
            span = $urandom_range(40, 300);
            period = $urandom_range(3, 12);
            repeat (span) begin
                @(negedge aclk);
                tick++;
                if (rx_free) begin
                    m_tready <= 1'b1;
                end else begin
                    case (style)
                        RX_ALWAYS:   m_tready <= 1'b1;
                        RX_RANDOM:   m_tready <= 1'($urandom_range(0, 1));
                        RX_SPARSE:   m_tready <= ($urandom_range(0, 7) == 0);
                        default:     m_tready <= ((tick % period) < period / 2);
                    endcase
                end
            end
        end
    end

    always @(posedge aclk) begin
        outcome_t got;
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[11:0];
            results_seen++;
            if (outcome_q.size() == 0) begin
                report_mismatch("unexpected result, tdata", int'(m_tdata), 0);
            end else begin
                want = outcome_q.pop_front();
                if (got.skip !== want.skip)
                    report_mismatch("skip", int'(got.skip), int'(want.skip));
                if (got.proc !== want.proc)
                    report_mismatch("process_other", int'(got.proc), int'(want.proc));
                if (got.depth !== want.depth)
                    report_mismatch("nest_depth", int'(got.depth), int'(want.depth));
                if (got.err !== want.err)
                    report_mismatch("error_code", int'(got.err), int'(want.err));
            end
        end
    end

    // watchdog: count cycles without any transfer
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired after %0d idle cycles", idle_cycles);
                $display("** conditional_nesting_stack: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        mismatches = 0;
        results_seen = 0;
        burst_left = 0;
        gap_max = 0;
        rx_free = 1'b0;
        grp_depth = 0;
        grp_skip = 1'b0;
        c23_en = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_error_cases();
        test_group_branches();
        test_c23_forms();
        test_overflow();
        test_random_traffic();

        drain_results();
        repeat (8) @(posedge aclk);
        if (outcome_q.size() != 0)
            report_mismatch("results still outstanding", 0, outcome_q.size());
        if (mismatches == 0)
            $display("** conditional_nesting_stack: PASSED **");
        else
            $display("** conditional_nesting_stack: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ===== conditional_nesting_stack.f =====
hw/rtl/cns_pkg.sv
hw/rtl/cns_ram.sv
hw/rtl/cns_ctrl.sv
hw/rtl/cns_datapath.sv
hw/rtl/conditional_nesting_stack.sv
tb/tb.sv
